@@ rtl/core/hchc_pkg.sv @@
// Shared types and constants for the hashed caller hit counter.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`default_nettype none

package hchc_pkg;

	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	localparam int KEY_W = 31;
	localparam int CNT_W = 32;
	localparam int ENTRY_W = KEY_W + CNT_W;

	localparam int ADDR_W = 64;
	localparam int IDX_W = 8;
	localparam int IN_DATA_W = ADDR_W + IDX_W;
	localparam int OUT_DATA_W = 1 + KEY_W + CNT_W + CNT_W;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [1:0] ST_COUNTED = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_WIN_BASE = 2'd1;
	localparam logic [1:0] REG_WIN_SIZE = 2'd2;

	typedef struct packed {
		logic load_in;
		logic clr_wr;
		logic sub;
		logic key_ld;
		logic mul;
		logic home;
		logic mem_rd;
		logic rd_item;
		logic hit;
		logic miss;
		logic lost;
		logic res_ignore;
		logic res_read;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic in_window;
		logic probe_hit;
		logic probe_last;
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/core/hashed_caller_hit_counter.sv @@
// Top level of the hashed caller hit counter: joins controller and datapath.
// Depends on hchc_pkg, hchc_ctrl and hchc_datapath.
//
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       s_tuser func, s_tdata address and slot
// m_*       out        m_tvalid / m_tready       m_tuser status, m_tdata slot and lost hits
// APB       in         psel, penable, pwrite     paddr 8*index, pwdata, prdata
//
// After reset every slot of the memory is cleared; s_tready stays low meanwhile.
// A read item passes S_RRD and S_RRES, reads its slot and goes to S_DONE to load the output register.
// A record item outside the window ends after the subtract and window check; one inside it is hashed,
// given its home slot and probed, each probe a read and compare on the single memory port.
// A full table costs SLOTS probes. Items are handled one at a time.
// A result held by m_tready low does not block acceptance of the next item.
`default_nettype none

module hashed_caller_hit_counter #(
	parameter int SLOTS = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [63:0] caller_address, [71:64] slot_index
	input  wire logic [hchc_pkg::IN_DATA_W-1:0]     s_tdata,
	// [0] func
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [0] slot_used, [31:1] slot_offset, [63:32] slot_count, [95:64] overflow_count
	output logic [hchc_pkg::OUT_DATA_W-1:0]         m_tdata,
	// [1:0] status
	output logic [1:0]                              m_tuser,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [hchc_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [hchc_pkg::PDATA_W-1:0]       pwdata,
	output logic [hchc_pkg::PDATA_W-1:0]            prdata,
	output logic                                    pready
);

	hchc_pkg::cmd_t cmd;
	hchc_pkg::sts_t sts;

	assign pready = 1'b1;

	hchc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_func   (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hchc_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

@@ rtl/core/hchc_ctrl.sv @@
// Controller state machine of the hashed caller hit counter.
// Sequences clearing, window check, hashing, probing, slot reads and result hand-off.
// Depends on hchc_pkg.
`default_nettype none

module hchc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	input  wire logic           s_func,
	output logic                s_tready,
	input  wire hchc_pkg::sts_t sts,
	output hchc_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SUB,
		S_WIN,
		S_MUL,
		S_HOME,
		S_PRD,
		S_PCHK,
		S_RRD,
		S_RRES,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = (s_func == hchc_pkg::FUNC_READ) ? S_RRD : S_SUB;
				end
			end
			S_RRD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_item = 1'b1;
				state_d = S_RRES;
			end
			S_RRES: begin
				cmd.res_read = 1'b1;
				state_d = S_DONE;
			end
			S_SUB: begin
				cmd.sub = 1'b1;
				state_d = S_WIN;
			end
			S_WIN: begin
				if (sts.in_window) begin
					cmd.key_ld = 1'b1;
					state_d = S_MUL;
				end else begin
					cmd.res_ignore = 1'b1;
					state_d = S_DONE;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_HOME;
			end
			S_HOME: begin
				cmd.home = 1'b1;
				state_d = S_PRD;
			end
			S_PRD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				priority if (sts.probe_hit) begin
					cmd.hit = 1'b1;
					state_d = S_DONE;
				end else if (sts.probe_last) begin
					cmd.lost = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.miss = 1'b1;
					state_d = S_PRD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hchc_datapath.sv @@
// Datapath of the hashed caller hit counter: configuration registers,
// window check, hash multiply, slot memory, lost-hit counter and output register.
// Depends on hchc_pkg; driven by hchc_ctrl.
`default_nettype none

module hchc_datapath #(
	parameter int SLOTS = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire hchc_pkg::cmd_t                      cmd,
	output hchc_pkg::sts_t                           sts,
	input  wire logic [hchc_pkg::IN_DATA_W-1:0]      s_tdata,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [hchc_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [hchc_pkg::PDATA_W-1:0]        pwdata,
	output logic [hchc_pkg::PDATA_W-1:0]             prdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [hchc_pkg::OUT_DATA_W-1:0]          m_tdata,
	output logic [1:0]                               m_tuser
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] SLOT_LAST = IW'(SLOTS - 1);
	localparam logic [PW-1:0] PROBE_LAST = PW'(SLOTS - 1);

	localparam int KW = hchc_pkg::KEY_W;
	localparam int CW = hchc_pkg::CNT_W;

	logic                       en_q;
	logic [63:0]                base_q;
	logic [KW-1:0]              size_q;

	logic [63:0]                addr_q;
	logic [7:0]                 idx_q;
	logic [64:0]                diff_q;
	logic [KW-1:0]              key_q;
	logic [31:0]                prod_q;
	logic [IW-1:0]              slot_q;
	logic [PW-1:0]              probe_q;
	logic [CW-1:0]              lost_q;

	logic [hchc_pkg::ENTRY_W-1:0] mem [SLOTS];
	logic [hchc_pkg::ENTRY_W-1:0] rd_q;
	logic [IW-1:0]              rd_addr;
	logic                       wr_en;
	logic [IW-1:0]              wr_addr;
	logic [hchc_pkg::ENTRY_W-1:0] wr_data;

	logic [KW-1:0]              rd_key;
	logic [CW-1:0]              rd_cnt;
	logic [CW-1:0]              cnt_inc;
	logic                       idx_in_range;
	logic                       cfg_wr;

	logic [1:0]                 res_status_q;
	logic                       res_used_q;
	logic [KW-1:0]              res_off_q;
	logic [CW-1:0]              res_cnt_q;
	logic                       out_valid_q;

	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			base_q <= '0;
			size_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				hchc_pkg::REG_ENABLE:   en_q <= pwdata[0];
				hchc_pkg::REG_WIN_BASE: base_q <= pwdata;
				hchc_pkg::REG_WIN_SIZE: size_q <= pwdata[KW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			hchc_pkg::REG_ENABLE:   prdata = {63'd0, en_q};
			hchc_pkg::REG_WIN_BASE: prdata = base_q;
			hchc_pkg::REG_WIN_SIZE: prdata = {33'd0, size_q};
			default:                prdata = '0;
		endcase
	end

	assign rd_key = rd_q[hchc_pkg::ENTRY_W-1:CW];
	assign rd_cnt = rd_q[CW-1:0];
	assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
	assign idx_in_range = (32'(idx_q) < SLOTS);

	assign sts.in_window = en_q && (base_q != '0) && !diff_q[64]
		&& (diff_q[63:KW] == '0) && (diff_q[KW-1:0] < size_q);
	assign sts.probe_hit = (rd_key == '0) || (rd_key == key_q);
	assign sts.probe_last = (probe_q == PROBE_LAST);
	assign sts.clr_last = (slot_q == SLOT_LAST);
	assign sts.out_free = !out_valid_q || m_tready;

	assign rd_addr = cmd.rd_item ? IW'(idx_q) : slot_q;
	assign wr_en = cmd.clr_wr || cmd.hit;
	assign wr_addr = slot_q;
	assign wr_data = cmd.hit ? {key_q, cnt_inc} : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			lost_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			end else if (cmd.home) begin
				slot_q <= prod_q[IW-1:0] & SLOT_LAST;
			end else if (cmd.miss) begin
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			end
			if (cmd.lost && (lost_q != '1)) begin
				lost_q <= lost_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			addr_q <= s_tdata[63:0];
			idx_q <= s_tdata[71:64];
		end
		if (cmd.sub) begin
			diff_q <= {1'b0, addr_q} - {1'b0, base_q};
		end
		if (cmd.key_ld) begin
			key_q <= diff_q[KW-1:0] + 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= 32'({1'b0, key_q} * hchc_pkg::HASH_MULT);
		end
		if (cmd.home) begin
			probe_q <= '0;
		end else if (cmd.miss) begin
			probe_q <= probe_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hit) begin
			res_status_q <= hchc_pkg::ST_COUNTED;
			res_used_q <= 1'b1;
			res_off_q <= key_q - 1'b1;
			res_cnt_q <= cnt_inc;
		end else if (cmd.lost) begin
			res_status_q <= hchc_pkg::ST_OVERFLOW;
			res_used_q <= 1'b0;
			res_off_q <= '0;
			res_cnt_q <= '0;
		end else if (cmd.res_ignore) begin
			res_status_q <= hchc_pkg::ST_IGNORED;
			res_used_q <= 1'b0;
			res_off_q <= '0;
			res_cnt_q <= '0;
		end else if (cmd.res_read) begin
			res_status_q <= hchc_pkg::ST_READ;
			res_used_q <= idx_in_range && (rd_key != '0);
			res_off_q <= (idx_in_range && (rd_key != '0)) ? rd_key - 1'b1 : '0;
			res_cnt_q <= idx_in_range ? rd_cnt : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {lost_q, res_cnt_q, res_off_q, res_used_q};
			m_tuser <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/hchc_checker.sv @@
// Port-level checks for the hashed caller hit counter, bound to its top level.
// Depends on hchc_pkg and hashed_caller_hit_counter.
`default_nettype none

module hchc_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [hchc_pkg::OUT_DATA_W-1:0]    m_tdata,
	input wire logic [1:0]                         m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result changed or vanished while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("A second item was taken while one was in work.");

	a_counted_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == hchc_pkg::ST_COUNTED) |-> m_tdata[0] && (m_tdata[63:32] != '0))
		else $error("Counted result without a used slot and a nonzero count.");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == hchc_pkg::ST_IGNORED) || (m_tuser == hchc_pkg::ST_OVERFLOW))
		|-> (m_tdata[63:0] == '0))
		else $error("Ignored or overflow result carries slot data.");

endmodule

bind hashed_caller_hit_counter hchc_checker u_hchc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ bench/tb_hashed_caller_hit_counter.sv @@
// Self-checking testbench for hashed_caller_hit_counter: record and read items go in on the
// stream input, and every result is checked against a predictor held in a scoreboard class.
// Depends on hchc_pkg and the RTL of the block; configuration is written over the APB port.
`default_nettype none

module tb_hashed_caller_hit_counter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SLOTS = 256;
	localparam logic [31:0] GOLDEN_MULT = 32'd2654435761;
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int DRAIN_LIMIT = 20_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [1:0]  status;
		logic        used;
		logic [30:0] offset;
		logic [31:0] count;
		logic [31:0] lost;
	} hit_result_t;

	class hit_table_scoreboard;
		logic [30:0] keys[TABLE_SLOTS];
		logic [31:0] counts[TABLE_SLOTS];
		logic [31:0] lost_hits;
		logic        enable;
		logic [63:0] win_base;
		logic [30:0] win_size;
		hit_result_t awaited[$];
		int          errors;

		function new();
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				keys[i] = '0;
				counts[i] = '0;
			end
			lost_hits = '0;
			enable = 1'b0;
			win_base = '0;
			win_size = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] value);
			case (idx)
				hchc_pkg::REG_ENABLE: begin
					enable = value[0];
				end
				hchc_pkg::REG_WIN_BASE: begin
					win_base = value;
				end
				hchc_pkg::REG_WIN_SIZE: begin
					win_size = value[30:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_item(logic fn, logic [63:0] addr, logic [7:0] idx);
			hit_result_t r;
			logic [63:0] offset;
			logic [63:0] prod;
			logic [30:0] key;
			int slot;
			bit placed;
			r = '0;
			if (fn == hchc_pkg::FUNC_READ) begin
				r.status = hchc_pkg::ST_READ;
				r.used = (keys[idx] != '0);
				r.offset = r.used ? keys[idx] - 31'd1 : '0;
				r.count = counts[idx];
			end else if (!enable || win_base == '0 || addr < win_base ||
					(addr - win_base) >= {33'b0, win_size}) begin
				r.status = hchc_pkg::ST_IGNORED;
			end else begin
				offset = addr - win_base;
				key = offset[30:0] + 31'd1;
				prod = {33'b0, key} * {32'b0, GOLDEN_MULT};
				slot = int'(prod & 64'(TABLE_SLOTS - 1));
				placed = 1'b0;
				for (int p = 0; p < TABLE_SLOTS && !placed; p++) begin
					if (keys[slot] == '0 || keys[slot] == key) begin
						keys[slot] = key;
						if (counts[slot] != 32'hFFFF_FFFF)
							counts[slot]++;
						r.status = hchc_pkg::ST_COUNTED;
						r.used = 1'b1;
						r.offset = key - 31'd1;
						r.count = counts[slot];
						placed = 1'b1;
					end else begin
						slot = (slot + 1 >= TABLE_SLOTS) ? 0 : slot + 1;
					end
				end
				if (!placed) begin
					if (lost_hits != 32'hFFFF_FFFF)
						lost_hits++;
					r.status = hchc_pkg::ST_OVERFLOW;
				end
			end
			r.lost = lost_hits;
			awaited = {awaited, r};
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			if (errors < PRINT_CAP)
				$display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
					want);
			errors++;
		endtask

		task check_result(logic [1:0] status, logic [hchc_pkg::OUT_DATA_W-1:0] data);
			hit_result_t want;
			if (awaited.size() == 0) begin
				report_mismatch("unexpected result status", {62'b0, status}, '0);
				return;
			end
			want = awaited.pop_front();
			if (status !== want.status)
				report_mismatch("status", {62'b0, status}, {62'b0, want.status});
			if (data[0] !== want.used)
				report_mismatch("slot_used", {63'b0, data[0]}, {63'b0, want.used});
			if (data[31:1] !== want.offset)
				report_mismatch("slot_offset", {33'b0, data[31:1]}, {33'b0, want.offset});
			if (data[63:32] !== want.count)
				report_mismatch("slot_count", {32'b0, data[63:32]}, {32'b0, want.count});
			if (data[95:64] !== want.lost)
				report_mismatch("overflow_count", {32'b0, data[95:64]}, {32'b0, want.lost});
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b1;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [hchc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                            s_tuser = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [hchc_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [1:0]                      m_tuser;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [hchc_pkg::PADDR_W-1:0]    paddr = '0;
	logic [hchc_pkg::PDATA_W-1:0]    pwdata = '0;
	logic [hchc_pkg::PDATA_W-1:0]    prdata;
	logic                            pready;

	hit_table_scoreboard hit_table;
	int cycle_count = 0;
	int tx_idle_pct = 20;
	int rx_idle_pct = 76;
	int rx_hold = 0;

	hashed_caller_hit_counter #(
		.SLOTS(TABLE_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				hit_table.check_result(m_tuser, m_tdata);
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic push_item(logic fn, logic [63:0] addr, logic [7:0] idx);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {idx, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		hit_table.note_item(fn, addr, idx);
		@(negedge clk);
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (hit_table.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [63:0] value);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		hit_table.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_random(int n, int hot_span, bit wide, int pause_at, bit hold_rx);
		logic [63:0] base;
		logic [63:0] size;
		logic [63:0] addr;
		int pick;
		base = hit_table.win_base;
		size = {33'b0, hit_table.win_size};
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) begin
				if (hold_rx)
					rx_hold = 400;
				else
					settle();
			end
			pick = $urandom_range(99);
			if (pick < 15) begin
				push_item(hchc_pkg::FUNC_READ, {$urandom, $urandom},
					8'($urandom_range(255)));
			end else if (pick < 25) begin
				push_item(hchc_pkg::FUNC_RECORD, {$urandom, $urandom},
					8'($urandom_range(255)));
			end else if (pick < 32) begin
				if ($urandom_range(1))
					addr = base - 64'd1 - 64'($urandom_range(3));
				else
					addr = base + size + 64'($urandom_range(3));
				push_item(hchc_pkg::FUNC_RECORD, addr, 8'($urandom_range(255)));
			end else begin
				if (wide && $urandom_range(99) < 30)
					addr = base + 64'($urandom_range(32'(size - 1)));
				else
					addr = base + 64'($urandom_range(hot_span - 1));
				push_item(hchc_pkg::FUNC_RECORD, addr, 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		hit_table = new();
		#1;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_item(hchc_pkg::FUNC_READ, 64'd0, 8'd0);
		push_item(hchc_pkg::FUNC_READ, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
		push_item(hchc_pkg::FUNC_RECORD, 64'd0, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		set_reg(hchc_pkg::REG_WIN_BASE, 64'h0000_0000_1000_0000);
		set_reg(hchc_pkg::REG_WIN_SIZE, 64'd16);
		push_item(hchc_pkg::FUNC_RECORD, 64'h0000_0000_1000_0000, 8'd0);
		set_reg(hchc_pkg::REG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFF);
		push_item(hchc_pkg::FUNC_RECORD, 64'h0000_0000_1000_0000, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'h0000_0000_1000_0000, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'h0000_0000_1000_000F, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'h0000_0000_1000_0010, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'h0000_0000_0FFF_FFFF, 8'd0);
		set_reg(hchc_pkg::REG_WIN_BASE, 64'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'd0, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'd5, 8'd0);
		set_reg(hchc_pkg::REG_WIN_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
		set_reg(hchc_pkg::REG_WIN_SIZE, 64'hFFFF_FFFF_8000_0010);
		push_item(hchc_pkg::FUNC_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'hFFFF_FFFF_FFFF_FFF0, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'hFFFF_FFFF_FFFF_FFEF, 8'd0);
		set_reg(hchc_pkg::REG_WIN_BASE, 64'd1);
		set_reg(hchc_pkg::REG_WIN_SIZE, 64'd2147483646);
		push_item(hchc_pkg::FUNC_RECORD, 64'd0, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'd1, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'd2147483646, 8'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'd2147483647, 8'd0);
		set_reg(hchc_pkg::REG_WIN_SIZE, 64'd0);
		push_item(hchc_pkg::FUNC_RECORD, 64'd1, 8'd0);
		set_reg(hchc_pkg::REG_ENABLE, 64'h2);
		push_item(hchc_pkg::FUNC_RECORD, 64'h0000_0000_1000_0000, 8'd0);

		set_reg(hchc_pkg::REG_ENABLE, 64'd1);
		set_reg(hchc_pkg::REG_WIN_BASE, {$urandom, $urandom} | 64'd1);
		set_reg(hchc_pkg::REG_WIN_SIZE, 64'd64);
		run_random(600, 64, 1'b0, 300, 1'b1);

		set_reg(hchc_pkg::REG_WIN_BASE, 64'hFFFF_FFFF_FFFF_FF00);
		set_reg(hchc_pkg::REG_WIN_SIZE, 64'd256);
		tx_idle_pct = 76;
		rx_idle_pct = 20;
		run_random(600, 256, 1'b0, 300, 1'b0);

		set_reg(hchc_pkg::REG_WIN_BASE, {$urandom, $urandom} | 64'd1);
		set_reg(hchc_pkg::REG_WIN_SIZE, 64'd2147483646);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(600, 300, 1'b1, -1, 1'b0);

		settle();
		repeat (20) @(posedge clk);
		if (hit_table.awaited.size() != 0)
			hit_table.report_mismatch("results never arrived",
				64'(hit_table.awaited.size()), '0);
		if (hit_table.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
